// ----- rtl/core/music_macro_note_parser_macros.svh -----
// ---------------------------------------------------------------------------
// music_macro_note_parser_macros.svh
// Assertion macros used by the note parser controller.
// ---------------------------------------------------------------------------
`ifndef MUSIC_MACRO_NOTE_PARSER_MACROS_SVH
`define MUSIC_MACRO_NOTE_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MMNP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MMNP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mmnp_pkg.sv -----
// ---------------------------------------------------------------------------
// mmnp_pkg
// Types and widths shared by the note parser controller and datapath.
// ---------------------------------------------------------------------------
package mmnp_pkg;

  localparam int CHAR_W = 8;
  localparam int TONE_W = 11;
  localparam int DUR_W  = 8;

  // Commands from the controller to the datapath; at most one is high.
  typedef struct packed {
    logic load;
    logic pre;
    logic dispatch;
    logic endstep;
    logic mul;
    logic div_init;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic pre_emit;
    logic pre_resume;
    logic end_emit;
    logic div_done;
  } dp_sts_t;

endpackage

// ----- rtl/core/mmnp_ctrl.sv -----
// ---------------------------------------------------------------------------
// mmnp_ctrl
// Sequencer for the note parser: steps one character through the parse
// phases and runs the note timing computation when a note is emitted.
// ---------------------------------------------------------------------------
`include "music_macro_note_parser_macros.svh"

module mmnp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mmnp_pkg::dp_cmd_t cmd,
  input  mmnp_pkg::dp_sts_t sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRE   = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_END   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DINIT = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // Where to continue once an emitted note has been transferred.
  localparam logic [1:0] AF_IDLE = 2'd0;
  localparam logic [1:0] AF_DISP = 2'd1;
  localparam logic [1:0] AF_END  = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] after_r, after_r_next;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    after_r_next = after_r;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        cmd.pre = 1'b1;
        if (sts.pre_emit) begin
          state_next   = S_MUL;
          after_r_next = sts.pre_resume ? AF_DISP : AF_END;
        end else if (sts.pre_resume) begin
          state_next = S_DISP;
        end else begin
          state_next = S_END;
        end
      end
      S_DISP: begin
        cmd.dispatch = 1'b1;
        state_next   = S_END;
      end
      S_END: begin
        cmd.endstep = 1'b1;
        if (sts.end_emit) begin
          state_next   = S_MUL;
          after_r_next = AF_IDLE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          unique case (after_r)
            AF_DISP: state_next = S_DISP;
            AF_END:  state_next = S_END;
            default: state_next = S_IDLE;
          endcase
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      after_r <= AF_IDLE;
    end else begin
      state   <= state_next;
      after_r <= after_r_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  `MMNP_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command")
  `MMNP_ASSERT_NEXT(a_accept_to_pre, in_valid && in_ready, state == S_PRE, "accept not followed by parse step")
  `MMNP_ASSERT_NEXT(a_div_to_fin, (state == S_DIV) && sts.div_done, state == S_FIN, "divider end missed")
  `MMNP_ASSERT_NEXT(a_last_to_idle, out_valid && out_ready && (after_r == AF_IDLE), in_ready, "final transfer did not free input")

endmodule

// ----- rtl/core/mmnp_dpath.sv -----
// ---------------------------------------------------------------------------
// mmnp_dpath
// Parse state, note setup, tick multiplier, restoring divider and the
// result register of the note parser.
// ---------------------------------------------------------------------------
module mmnp_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  mmnp_pkg::dp_cmd_t             cmd,
  output mmnp_pkg::dp_sts_t             sts,
  input  logic [mmnp_pkg::CHAR_W-1:0]   char_code,
  input  logic                          string_start,
  input  logic                          string_end,
  output logic [mmnp_pkg::TONE_W-1:0]   tone_hz,
  output logic [mmnp_pkg::DUR_W-1:0]    duration_ticks,
  output logic                          is_pause,
  output logic                          last_of_run
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_TEMPO    = 3'd1;
  localparam logic [2:0] PH_OCT      = 3'd2;
  localparam logic [2:0] PH_LEN      = 3'd3;
  localparam logic [2:0] PH_NOTE     = 3'd4;
  localparam logic [2:0] PH_NOTE_NUM = 3'd5;

  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_UP    = 8'h3E;
  localparam logic [7:0] CH_DOWN  = 8'h3C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'd32;

  localparam logic [11:0] TEMPO_RESET = 12'd120;
  localparam logic [11:0] TEMPO_MIN   = 12'd32;
  localparam logic [11:0] LEN_RESET   = 12'd4;
  localparam logic [11:0] NUM_MAX     = 12'd4095;
  localparam logic [12:0] OCT_RESET   = 13'd4;
  localparam logic [12:0] OCT_MAX     = 13'h0FFF;
  localparam logic [12:0] OCT_MIN     = 13'h1000;
  localparam logic [12:0] TICK_BASE   = 13'd4368;
  localparam logic [3:0]  SEMI_TOP    = 4'd11;

  function automatic logic [8:0] semitone_hz(input logic [3:0] s);
    logic [8:0] f;
    unique case (s)
      4'd0:    f = 9'd262;
      4'd1:    f = 9'd277;
      4'd2:    f = 9'd294;
      4'd3:    f = 9'd311;
      4'd4:    f = 9'd330;
      4'd5:    f = 9'd349;
      4'd6:    f = 9'd370;
      4'd7:    f = 9'd392;
      4'd8:    f = 9'd415;
      4'd9:    f = 9'd440;
      4'd10:   f = 9'd466;
      4'd11:   f = 9'd494;
      default: f = 9'd262;
    endcase
    return f;
  endfunction

  // A pause takes the semitone of B.
  function automatic logic [3:0] letter_semitone(input logic [7:0] c);
    logic [3:0] s;
    unique case (c)
      CH_C:    s = 4'd0;
      CH_D:    s = 4'd2;
      CH_E:    s = 4'd4;
      CH_F:    s = 4'd5;
      CH_G:    s = 4'd7;
      CH_A:    s = 4'd9;
      CH_B:    s = 4'd11;
      default: s = 4'd11;
    endcase
    return s;
  endfunction

  // Parse state.
  logic [7:0]  char_r;
  logic        end_r;
  logic [11:0] tempo;
  logic [12:0] octave;
  logic [11:0] def_len;
  logic [2:0]  phase;
  logic [11:0] acc;
  logic [3:0]  semi;
  logic        pause;

  // Note computation.
  logic [11:0] len_r;
  logic [10:0] hz_r;
  logic        pause_r;
  logic        dotted_r;
  logic        last_r;
  logic [23:0] prod_r;
  logic [30:0] dsh;
  logic [12:0] rem;
  logic [7:0]  quo;
  logic [2:0]  cnt;

  logic [7:0]  char_folded;
  logic        is_digit, is_letter, is_sharp, is_flat, is_dot;
  logic [3:0]  digit_val;
  logic [15:0] acc_x10;
  logic [11:0] acc_digit;
  logic        tlo_phase, note_phase, emit_setup;
  logic [11:0] len_sel, tempo_fix;
  logic [2:0]  oct_clamp;
  logic [10:0] hz_wide, hz_calc;
  logic [30:0] rem_wide;
  logic [9:0]  quo_x3;
  logic [8:0]  ticks_raw;

  assign char_folded = ((char_code >= CH_LOW_A) && (char_code <= CH_LOW_Z)) ?
                       (char_code - CASE_GAP) : char_code;

  assign is_digit  = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
  assign digit_val = 4'(char_r - CH_ZERO);
  assign is_letter = ((char_r >= CH_A) && (char_r <= CH_G)) || (char_r == CH_P);
  assign is_sharp  = (char_r == CH_PLUS) || (char_r == CH_HASH);
  assign is_flat   = (char_r == CH_MINUS);
  assign is_dot    = (char_r == CH_DOT);

  assign acc_x10   = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {12'd0, digit_val};
  assign acc_digit = (acc_x10 > {4'd0, NUM_MAX}) ? NUM_MAX : acc_x10[11:0];

  assign tlo_phase  = (phase == PH_TEMPO) || (phase == PH_OCT) || (phase == PH_LEN);
  assign note_phase = (phase == PH_NOTE) || (phase == PH_NOTE_NUM);

  assign sts.pre_emit   = note_phase && !is_digit &&
                          !((phase == PH_NOTE) && (is_sharp || is_flat));
  assign sts.pre_resume = tlo_phase ? !is_digit :
                          note_phase ? (sts.pre_emit && !is_dot) : 1'b1;
  assign sts.end_emit   = end_r && note_phase;
  assign sts.div_done   = (cnt == 3'd7);

  assign emit_setup = (cmd.pre && sts.pre_emit) || (cmd.endstep && sts.end_emit);

  // Length, tempo and octave fix-ups applied when a note is emitted.
  assign len_sel   = (acc != 12'd0) ? acc : ((def_len != 12'd0) ? def_len : LEN_RESET);
  assign tempo_fix = (tempo < TEMPO_MIN) ? TEMPO_RESET : tempo;
  assign oct_clamp = octave[12] ? 3'd0 : ((octave[11:0] > 12'd6) ? 3'd6 : octave[2:0]);
  assign hz_wide   = {2'b00, semitone_hz(semi)};
  assign hz_calc   = (oct_clamp < 3'd4) ? (hz_wide >> (3'd4 - oct_clamp)) :
                                          (hz_wide << (oct_clamp - 3'd4));

  always_ff @(posedge clk) begin
    if (rst) begin
      tempo   <= TEMPO_RESET;
      octave  <= OCT_RESET;
      def_len <= LEN_RESET;
      phase   <= PH_IDLE;
      acc     <= '0;
      semi    <= '0;
      pause   <= 1'b0;
    end else begin
      if (cmd.load && string_start) begin
        tempo   <= TEMPO_RESET;
        octave  <= OCT_RESET;
        def_len <= LEN_RESET;
        phase   <= PH_IDLE;
        acc     <= '0;
        semi    <= '0;
        pause   <= 1'b0;
      end
      if (cmd.pre) begin
        if (tlo_phase) begin
          if (is_digit) begin
            acc <= acc_digit;
          end else begin
            if (phase == PH_TEMPO) tempo <= acc;
            else if (phase == PH_OCT) octave <= {1'b0, acc};
            else def_len <= acc;
            phase <= PH_IDLE;
            acc   <= '0;
          end
        end else if (note_phase) begin
          if (is_digit) begin
            acc   <= acc_digit;
            phase <= PH_NOTE_NUM;
          end else if ((phase == PH_NOTE) && is_sharp) begin
            semi  <= (semi == SEMI_TOP) ? 4'd0 : semi + 4'd1;
            phase <= PH_NOTE_NUM;
          end else if ((phase == PH_NOTE) && is_flat) begin
            semi  <= (semi == 4'd0) ? SEMI_TOP : semi - 4'd1;
            phase <= PH_NOTE_NUM;
          end
        end else begin
          phase <= PH_IDLE;
        end
      end
      if (cmd.dispatch) begin
        if ((char_r == CH_T) || (char_r == CH_O) || (char_r == CH_L)) begin
          phase <= (char_r == CH_T) ? PH_TEMPO : ((char_r == CH_O) ? PH_OCT : PH_LEN);
          acc   <= '0;
        end else if (char_r == CH_UP) begin
          if (octave != OCT_MAX) octave <= octave + 13'd1;
        end else if (char_r == CH_DOWN) begin
          if (octave != OCT_MIN) octave <= octave - 13'd1;
        end else if (is_letter) begin
          pause <= (char_r == CH_P);
          semi  <= letter_semitone(char_r);
          acc   <= '0;
          phase <= PH_NOTE;
        end
      end
      // A pending note at the end of the string is flushed by the emit below.
      if (cmd.endstep && end_r && !note_phase) begin
        if (phase == PH_TEMPO) tempo <= acc;
        else if (phase == PH_OCT) octave <= {1'b0, acc};
        else if (phase == PH_LEN) def_len <= acc;
        phase <= PH_IDLE;
        acc   <= '0;
      end
      if (emit_setup) begin
        tempo  <= tempo_fix;
        octave <= {10'd0, oct_clamp};
        phase  <= PH_IDLE;
        acc    <= '0;
      end
    end
  end

  // Restoring divide of the tick base by tempo times length; the quotient
  // never exceeds 136, so eight quotient bits suffice.
  assign rem_wide  = {18'd0, rem};
  assign quo_x3    = {1'b0, quo, 1'b0} + {2'b00, quo};
  assign ticks_raw = dotted_r ? quo_x3[9:1] : {1'b0, quo};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= char_folded;
      end_r  <= string_end;
    end
    if (emit_setup) begin
      len_r    <= len_sel;
      hz_r     <= hz_calc;
      pause_r  <= pause;
      dotted_r <= cmd.pre && is_dot;
      last_r   <= cmd.endstep || !(end_r && is_letter);
    end
    if (cmd.mul) begin
      prod_r <= {12'd0, tempo} * {12'd0, len_r};
    end
    if (cmd.div_init) begin
      dsh <= {prod_r, 7'd0};
      rem <= TICK_BASE;
      quo <= '0;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      if (rem_wide >= dsh) begin
        rem <= 13'(rem_wide - dsh);
        quo <= {quo[6:0], 1'b1};
      end else begin
        quo <= {quo[6:0], 1'b0};
      end
      dsh <= dsh >> 1;
      cnt <= cnt + 3'd1;
    end
    if (cmd.finish) begin
      tone_hz        <= hz_r;
      duration_ticks <= (ticks_raw == 9'd0) ? 8'd1 : ticks_raw[7:0];
      is_pause       <= pause_r;
      last_of_run    <= last_r;
    end
  end

endmodule

// ----- rtl/core/music_macro_note_parser.sv -----
// Each character passes through the parse, dispatch and end steps; a character consumed by a
// pending number or note skips dispatch. Each note emitted adds the multiply, divider setup,
// 8 divider steps, result load and output. A new character is taken only once the last one
// and its notes are done, and a waiting result stalls the input until out_ready.
// Reset: synchronous, active high; tempo 120, octave 4, length 4, parse state cleared.
// ---------------------------------------------------------------------------
// music_macro_note_parser
// Parses a music-macro string one character per transfer and produces notes
// with a tone frequency and a duration in timer ticks.
// ---------------------------------------------------------------------------
module music_macro_note_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mmnp_pkg::CHAR_W-1:0] char_code,
  input  logic                        string_start,
  input  logic                        string_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mmnp_pkg::TONE_W-1:0] tone_hz,
  output logic [mmnp_pkg::DUR_W-1:0]  duration_ticks,
  output logic                        is_pause,
  output logic                        last_of_run
);

  // The controller walks each character through a sequence: the transfer
  // cycle latches it (and applies the start flag), a parse step finishes
  // any pending number or note, a dispatch step acts on the character
  // unless parsing consumed it, and an end step flushes pending work when
  // the end flag is set. Whenever a note is emitted the controller detours
  // through the multiply, divide and result states before picking up where
  // it left. One character can therefore produce two notes: the note it
  // terminates and, with the end flag, the note it starts.
  mmnp_pkg::dp_cmd_t cmd;
  mmnp_pkg::dp_sts_t sts;

  mmnp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the tempo, octave and length registers, the parse
  // phase and number accumulator, and the arithmetic for each note. Its
  // result register is loaded once per note and held until the transfer.
  mmnp_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .char_code      (char_code),
    .string_start   (string_start),
    .string_end     (string_end),
    .tone_hz        (tone_hz),
    .duration_ticks (duration_ticks),
    .is_pause       (is_pause),
    .last_of_run    (last_of_run)
  );

endmodule

// ----- tb/note_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// note_checker
// Watches both channels of the note parser. It keeps its own copy of the
// parser state, works out the notes that each accepted character causes,
// and compares every note that leaves the block against the oldest one due.
// ---------------------------------------------------------------------------
module note_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [mmnp_pkg::CHAR_W-1:0] char_code,
  input  logic                        string_start,
  input  logic                        string_end,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [mmnp_pkg::TONE_W-1:0] tone_hz,
  input  logic [mmnp_pkg::DUR_W-1:0]  duration_ticks,
  input  logic                        is_pause,
  input  logic                        last_of_run,
  output int                          mismatches,
  output int                          notes_waiting
);

  localparam int unsigned TICKS_PER_BEAT = 4368;
  localparam int unsigned DEFAULT_TEMPO  = 120;
  localparam int unsigned SLOWEST_TEMPO  = 32;
  localparam int unsigned DEFAULT_LENGTH = 4;
  localparam int unsigned NUMBER_CEILING = 4095;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_TEMPO,
    SCAN_OCTAVE,
    SCAN_LENGTH,
    SCAN_NOTE,
    SCAN_NOTE_NUM
  } scan_t;

  typedef struct packed {
    logic [mmnp_pkg::TONE_W-1:0] tone;
    logic [mmnp_pkg::DUR_W-1:0]  ticks;
    logic                        rest;
    logic                        last;
  } note_t;

  logic [11:0]        tempo;
  logic signed [12:0] octave;
  logic [11:0]        def_len;
  scan_t              scan;
  logic [11:0]        num;
  logic [3:0]         semi;
  logic               rest_flag;

  note_t notes_due[$];
  note_t run_notes[$];
  int    errs = 0;

  function automatic void load_defaults();
    tempo     = 12'(DEFAULT_TEMPO);
    octave    = 13'sd4;
    def_len   = 12'(DEFAULT_LENGTH);
    scan      = SCAN_IDLE;
    num       = '0;
    semi      = '0;
    rest_flag = 1'b0;
  endfunction

  function automatic int unsigned semitone_hz(logic [3:0] s);
    case (s)
      4'd0:    return 262;
      4'd1:    return 277;
      4'd2:    return 294;
      4'd3:    return 311;
      4'd4:    return 330;
      4'd5:    return 349;
      4'd6:    return 370;
      4'd7:    return 392;
      4'd8:    return 415;
      4'd9:    return 440;
      4'd10:   return 466;
      default: return 494;
    endcase
  endfunction

  function automatic logic [3:0] semitone_of(logic [7:0] c);
    case (c)
      "C":     return 4'd0;
      "D":     return 4'd2;
      "E":     return 4'd4;
      "F":     return 4'd5;
      "G":     return 4'd7;
      "A":     return 4'd9;
      default: return 4'd11;
    endcase
  endfunction

  function automatic void push_digit(logic [3:0] d);
    int unsigned v;
    v   = num * 10 + d;
    num = 12'((v > NUMBER_CEILING) ? NUMBER_CEILING : v);
  endfunction

  // A pending T, O or L number takes effect and the scanner goes idle.
  function automatic void close_field();
    case (scan)
      SCAN_TEMPO:  tempo = num;
      SCAN_OCTAVE: octave = {1'b0, num};
      SCAN_LENGTH: def_len = num;
      default: ;
    endcase
    scan = SCAN_IDLE;
    num  = '0;
  endfunction

  // Slow tempo and out-of-range octave are corrected here and kept.
  function automatic void emit_note(bit dotted);
    int unsigned len;
    int unsigned ticks;
    int unsigned hz;
    note_t       n;
    len = 32'(num);
    if (len == 0) len = 32'(def_len);
    if (len == 0) len = DEFAULT_LENGTH;
    if (tempo < SLOWEST_TEMPO) tempo = 12'(DEFAULT_TEMPO);
    ticks = TICKS_PER_BEAT / (tempo * len);
    if (dotted) ticks = ticks * 3 / 2;
    if (ticks < 1) ticks = 1;
    if (octave < 0) octave = '0;
    if (octave > 6) octave = 13'sd6;
    hz = semitone_hz(semi);
    if (octave < 4) hz = hz >> (4 - octave);
    else hz = hz << (octave - 4);
    n.tone  = mmnp_pkg::TONE_W'(hz);
    n.ticks = mmnp_pkg::DUR_W'(ticks);
    n.rest  = rest_flag;
    n.last  = 1'b0;
    run_notes.push_back(n);
    scan = SCAN_IDLE;
    num  = '0;
  endfunction

  function automatic void take_char(logic [7:0] code);
    logic [7:0] c;
    bit         digit;
    c = code;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    digit = (c >= "0" && c <= "9");

    if (scan == SCAN_TEMPO || scan == SCAN_OCTAVE || scan == SCAN_LENGTH) begin
      if (digit) begin
        push_digit(4'(c - "0"));
        return;
      end
      close_field();
    end else if (scan == SCAN_NOTE || scan == SCAN_NOTE_NUM) begin
      if (digit) begin
        push_digit(4'(c - "0"));
        scan = SCAN_NOTE_NUM;
        return;
      end
      // Accidentals are only taken right after the letter.
      if (scan == SCAN_NOTE && (c == "+" || c == "#")) begin
        semi = (semi == 4'd11) ? 4'd0 : semi + 4'd1;
        scan = SCAN_NOTE_NUM;
        return;
      end
      if (scan == SCAN_NOTE && c == "-") begin
        semi = (semi == 4'd0) ? 4'd11 : semi - 4'd1;
        scan = SCAN_NOTE_NUM;
        return;
      end
      if (c == ".") begin
        emit_note(1'b1);
        return;
      end
      emit_note(1'b0);
    end else begin
      scan = SCAN_IDLE;
    end

    if (c == "T") begin
      scan = SCAN_TEMPO;
      num  = '0;
    end else if (c == "O") begin
      scan = SCAN_OCTAVE;
      num  = '0;
    end else if (c == "L") begin
      scan = SCAN_LENGTH;
      num  = '0;
    end else if (c == ">") begin
      if (octave < 4095) octave = octave + 13'sd1;
    end else if (c == "<") begin
      if (octave > -4096) octave = octave - 13'sd1;
    end else if (c == "P" || (c >= "A" && c <= "G")) begin
      rest_flag = (c == "P");
      semi      = semitone_of(c);
      num       = '0;
      scan      = SCAN_NOTE;
    end
  endfunction

  function automatic void predict_char(logic [7:0] code, logic first, logic stop);
    note_t n;
    run_notes.delete();
    if (first) load_defaults();
    take_char(code);
    if (stop) begin
      if (scan == SCAN_NOTE || scan == SCAN_NOTE_NUM) emit_note(1'b0);
      else close_field();
    end
    for (int i = 0; i < run_notes.size(); i++) begin
      n      = run_notes[i];
      n.last = (i == run_notes.size() - 1);
      notes_due.push_back(n);
    end
  endfunction

  function automatic void check_note();
    note_t want;
    if (notes_due.size() == 0) begin
      $display("%0t: note with none due, expected nothing actual tone %0d ticks %0d",
               $time, tone_hz, duration_ticks);
      errs++;
      return;
    end
    want = notes_due.pop_front();
    if (tone_hz !== want.tone) begin
      $display("%0t: tone_hz expected %0d actual %0d", $time, want.tone, tone_hz);
      errs++;
    end
    if (duration_ticks !== want.ticks) begin
      $display("%0t: duration_ticks expected %0d actual %0d", $time, want.ticks,
               duration_ticks);
      errs++;
    end
    if (is_pause !== want.rest) begin
      $display("%0t: is_pause expected %0d actual %0d", $time, want.rest, is_pause);
      errs++;
    end
    if (last_of_run !== want.last) begin
      $display("%0t: last_of_run expected %0d actual %0d", $time, want.last, last_of_run);
      errs++;
    end
  endfunction

  // Outgoing notes are checked before the character of the same edge is
  // predicted, so a note can never be matched against its own prediction.
  always @(posedge clk) begin
    if (rst) begin
      load_defaults();
      notes_due.delete();
    end else begin
      if (out_valid && out_ready) check_note();
      if (in_valid && in_ready) predict_char(char_code, string_start, string_end);
    end
    mismatches    <= errs;
    notes_waiting <= notes_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Feeds the note parser with directed strings and random music-macro
// phrases under random idling on both channels, and gives the verdict from
// the failure count of the checker that sits beside the block.
// ---------------------------------------------------------------------------
module tb_top;

  // The long receiver hold is the longest quiet stretch a correct run can show.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 490;
  localparam int CALM_ITEMS     = 80;
  localparam int HOLD_AT_ITEM   = 150;
  localparam int SETTLE_CYCLES  = 40;

  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        in_valid     = 1'b0;
  logic                        in_ready;
  logic [mmnp_pkg::CHAR_W-1:0] char_code    = '0;
  logic                        string_start = 1'b0;
  logic                        string_end   = 1'b0;
  logic                        out_valid;
  logic                        out_ready    = 1'b0;
  logic [mmnp_pkg::TONE_W-1:0] tone_hz;
  logic [mmnp_pkg::DUR_W-1:0]  duration_ticks;
  logic                        is_pause;
  logic                        last_of_run;

  int mismatches;
  int notes_waiting;

  // Stimulus controls shared with the receiver process. They are written
  // with nonblocking assignments so that both processes see them in order.
  bit idle_on   = 1'b0;
  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;

  int quiet_cycles = 0;
  int items_done   = 0;

  // Characters of the phrase that is about to be sent.
  logic [7:0] phrase[$];

  always #1 clk = ~clk;

  music_macro_note_parser i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_code      (char_code),
    .string_start   (string_start),
    .string_end     (string_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tone_hz        (tone_hz),
    .duration_ticks (duration_ticks),
    .is_pause       (is_pause),
    .last_of_run    (last_of_run)
  );

  note_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_code      (char_code),
    .string_start   (string_start),
    .string_end     (string_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tone_hz        (tone_hz),
    .duration_ticks (duration_ticks),
    .is_pause       (is_pause),
    .last_of_run    (last_of_run),
    .mismatches     (mismatches),
    .notes_waiting  (notes_waiting)
  );

  // The watchdog restarts on every transfer of either channel. If the block
  // hangs or swallows a note for good, the run ends here as a failure.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver. It normally takes every note, drops ready for short random
  // bursts while idling is on, and once holds off for a long stretch so that
  // the block backs up and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
        hold_done <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) phrase.push_back(s[i]);
  endfunction

  function automatic void add_number(input int unsigned v);
    add_text($sformatf("%0d", v));
  endfunction

  // Mostly a value in the useful range, now and then one far past the
  // 4095 ceiling so that saturation is exercised.
  function automatic int unsigned pick_number(input int unsigned lo, input int unsigned hi);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 99999);
    return $urandom_range(lo, hi);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return ($urandom_range(0, 1) == 1) ? c + 8'd32 : c;
  endfunction

  // Appends one command of the macro language, or a stray byte as noise, to
  // the phrase and returns how many characters it added.
  function automatic int add_token();
    string       letters = "ABCDEFGP";
    string       marks   = "+#-";
    int unsigned pick;
    int          start_len;
    start_len = phrase.size();
    pick      = $urandom_range(0, 99);
    if (pick < 55) begin
      phrase.push_back(fold_case(letters[$urandom_range(0, 7)]));
      if ($urandom_range(0, 2) == 0) phrase.push_back(marks[$urandom_range(0, 2)]);
      if ($urandom_range(0, 1) == 0) add_number(pick_number(0, 64));
      if ($urandom_range(0, 3) == 0) phrase.push_back(".");
    end else if (pick < 65) begin
      phrase.push_back(fold_case("T"));
      if ($urandom_range(0, 7) != 0) add_number(pick_number(20, 300));
    end else if (pick < 73) begin
      phrase.push_back(fold_case("O"));
      if ($urandom_range(0, 7) != 0) add_number(pick_number(0, 8));
    end else if (pick < 81) begin
      phrase.push_back(fold_case("L"));
      if ($urandom_range(0, 7) != 0) add_number(pick_number(0, 64));
    end else if (pick < 87) begin
      phrase.push_back(">");
    end else if (pick < 93) begin
      phrase.push_back("<");
    end else begin
      phrase.push_back(8'($urandom_range(0, 255)));
    end
    return phrase.size() - start_len;
  endfunction

  // One character transfer. An idle burst may come first; after that valid
  // stays high with the same payload until the block takes it. Ready is read
  // right after the edge, so it is the value the edge itself saw.
  task automatic send_char(input logic [7:0] code, input bit first, input bit stop);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_code    <= code;
    string_start <= first;
    string_end   <= stop;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_phrase(input bit first, input bit stop);
    for (int i = 0; i < phrase.size(); i++) begin
      send_char(phrase[i], first && i == 0, stop && i == phrase.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    phrase.delete();
    add_text(s);
    send_phrase(1'b1, 1'b1);
  endtask

  // The sender pauses until every predicted note has come out. The count
  // from the checker is registered, hence the first clock before looking.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (notes_waiting != 0) @(posedge clk);
  endtask

  initial begin
    int counted;

    repeat (7) @(posedge clk);
    rst     <= 1'b0;
    idle_on <= 1'b1;

    // Directed strings. Tempo saturates at 4095 and a zero default length
    // falls back to four, giving the shortest duration of one tick.
    send_text("T99999L0C");
    // Lower case, empty numbers for tempo, octave and length, C flat wraps
    // to B, and the dot ends the note with a dotted length.
    send_text("tolc-.");
    // Octave saturates at the top, B sharp wraps to C, the next letter ends
    // the note and the end flag flushes it: two notes from one character.
    send_text("O9999>B+8G");
    // A sharpened pause ended by NUL, then a byte with every bit set.
    send_char("P", 1'b1, 1'b0);
    send_char("#", 1'b0, 1'b0);
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b1);
    // An accidental after the length ends the note and is then dropped.
    send_text("E16-");
    drain();

    // Octave below zero: stepping down from zero, then a note clamps the
    // octave back to zero.
    send_text("O0<<<C");
    drain();

    // Random phrases of well-formed commands with some noise mixed in. A
    // phrase does not always start or end the string, so state carries over.
    while (items_done < RANDOM_ITEMS) begin
      phrase.delete();
      counted = 0;
      repeat ($urandom_range(1, 10)) counted += add_token();
      send_phrase($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
      items_done += counted;
      if (!hold_go && items_done >= HOLD_AT_ITEM) hold_go <= 1'b1;
      // The last stretch runs with both sides at full rate.
      if (items_done >= RANDOM_ITEMS - CALM_ITEMS) idle_on <= 1'b0;
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
